### rtl/lfu_cache_table_unit_defines.svh
// Assertion macros for the LFU cache table unit.
// Used by the top level; depends on nothing else.
`ifndef LFU_CACHE_TABLE_UNIT_DEFINES_SVH
`define LFU_CACHE_TABLE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LFU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lfu_cache_table_unit: check failed");
`define LFU_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lfu_cache_table_unit: check failed");
`else
`define LFU_ASSERT(label, prop)
`define LFU_ASSERT_RST(label, prop)
`endif
`endif

### rtl/lfu_pkg.sv
// Shared types and constants of the LFU cache table unit.
// No dependencies.
package lfu_pkg;

    localparam int DEF_ENTRIES  = 16;
    localparam int DEF_KEY_BITS = 32;
    localparam int DATA_W       = 32;
    localparam int KEY_IN_W     = 32;
    localparam int COUNT_W      = 32;
    localparam int CAP_W        = 5;

    localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0]  MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 32'd1;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } lfu_state_t;

    typedef enum logic [1:0] {
        OP_BUMP_GET,
        OP_BUMP_PUT,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        logic     commit;
        cell_op_t op;
        logic     rank_all;
    } cell_cmd_t;

endpackage

### rtl/lfu_if.sv
// Handshake channels of the LFU cache table unit: request, response, config.
// Depends on lfu_pkg.
interface lfu_req_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic signed [lfu_pkg::KEY_IN_W-1:0] lookup_key;
    logic signed [lfu_pkg::DATA_W-1:0]   write_value;
    modport source (output valid, action, lookup_key, write_value, input ready);
    modport sink (input valid, action, lookup_key, write_value, output ready);
endinterface

interface lfu_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic signed [lfu_pkg::DATA_W-1:0]   read_value;
    logic                              evicted;
    logic signed [lfu_pkg::KEY_IN_W-1:0] evicted_key;
    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lfu_pkg::CAP_W-1:0]  cache_capacity;
    modport source (output valid, cache_capacity, input ready);
    modport sink (input valid, cache_capacity, output ready);
endinterface

### rtl/lfu_cache_table_unit.sv
// Top level of the LFU cache table unit: sequencer, config and the row of cells.
// Depends on lfu_pkg, lfu_if.sv, lfu_cell and lfu_cache_table_unit_defines.svh.
//
// Usage:
//   req  : one transfer per operation (action 0 = get, 1 = put, key, value).
//   rsp  : one transfer per request: hit, read value, evicted flag and key.
//   cfg  : writes cache_capacity; always ready, write only while idle.
// Sequencing:
//   A request is taken when the unit is idle. Hits, misses on get and puts
//   into a free slot commit in the cycle after the transfer unless the
//   response register is still full; no new request is taken before the
//   last one commits. A put that must evict waits for the victim to travel
//   the cell chain (lowest use count, oldest among equals), then commits.
//   The response shows on rsp the cycle after commit.
// Reset:
//   The table is empty and capacity is 16; no clearing pass is needed.
// Stall:
//   The next request may be taken while a response waits; its commit holds
//   until the response register is free.
`include "lfu_cache_table_unit_defines.svh"
module lfu_cache_table_unit #(
    parameter int ENTRIES  = lfu_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = lfu_pkg::DEF_KEY_BITS
) (
    input  logic  clk,
    input  logic  rst_n,
    lfu_req_if.sink   req,
    lfu_rsp_if.source rsp,
    lfu_cfg_if.sink   cfg
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > lfu_pkg::CAP_W) ? FILL_W : lfu_pkg::CAP_W;
    localparam int DW     = lfu_pkg::DATA_W;
    localparam int CW     = lfu_pkg::COUNT_W;

    lfu_pkg::lfu_state_t state_reg, state_next;

    logic [lfu_pkg::CAP_W-1:0] cap_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         cnt_reg, cnt_next;
    logic                      act_reg;
    logic [KEY_BITS-1:0]       key_reg;
    logic [DW-1:0]             val_reg;

    logic                      out_v_reg;
    logic                      out_hit_reg;
    logic [DW-1:0]             out_val_reg;
    logic                      out_ev_reg;
    logic [lfu_pkg::KEY_IN_W-1:0] out_evkey_reg;

    logic                      accept;
    logic                      commit;
    logic                      out_free;
    lfu_pkg::cell_cmd_t        cmd;

    logic [ENTRIES-1:0]        match_vec;
    logic [ENTRIES-1:0]        valid_vec;
    logic [ENTRIES-1:0]        sel_vec;
    logic [ENTRIES-1:0]        free_oh;
    logic [ENTRIES-1:0]        victim_oh;
    logic [DW-1:0]             value_arr [ENTRIES];
    logic [IDX_W-1:0]          rank_arr  [ENTRIES];

    logic                      cv    [ENTRIES+1];
    logic [CW-1:0]             ccnt  [ENTRIES+1];
    logic [IDX_W-1:0]          crank [ENTRIES+1];
    logic [IDX_W-1:0]          cidx  [ENTRIES+1];
    logic [KEY_BITS-1:0]       ckey  [ENTRIES+1];

    logic                      present;
    logic [DW-1:0]             found_val;
    logic [IDX_W-1:0]          found_rank;
    logic [IDX_W-1:0]          thr_rank;
    logic [CMP_W-1:0]          cap_eff;
    logic                      cap_zero;
    logic                      need_victim;
    logic                      do_update;
    logic                      insert_free;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lfu_pkg::CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.cache_capacity;
        end
    end

    // row of cells and victim chain
    assign cv[0]    = 1'b0;
    assign ccnt[0]  = '0;
    assign crank[0] = '0;
    assign cidx[0]  = '0;
    assign ckey[0]  = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lfu_cell #(
            .KEY_BITS (KEY_BITS),
            .IDX_W    (IDX_W),
            .INDEX    (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .sel        (sel_vec[i]),
            .thr_rank   (thr_rank),
            .req_key    (key_reg),
            .req_value  (val_reg),
            .match      (match_vec[i]),
            .valid      (valid_vec[i]),
            .value      (value_arr[i]),
            .rank       (rank_arr[i]),
            .prev_v     (cv[i]),
            .prev_count (ccnt[i]),
            .prev_rank  (crank[i]),
            .prev_idx   (cidx[i]),
            .prev_key   (ckey[i]),
            .cand_v     (cv[i+1]),
            .cand_count (ccnt[i+1]),
            .cand_rank  (crank[i+1]),
            .cand_idx   (cidx[i+1]),
            .cand_key   (ckey[i+1])
        );
        assign victim_oh[i] = (cidx[ENTRIES] == IDX_W'(i));
    end

    // keys are unique among valid entries, so an OR of the masked fields selects
    always_comb
    begin
        found_val  = '0;
        found_rank = '0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            found_val  = found_val  | (value_arr[j] & {DW{match_vec[j]}});
            found_rank = found_rank | (rank_arr[j]  & {IDX_W{match_vec[j]}});
        end
    end

    assign present  = |match_vec;
    assign free_oh  = ~valid_vec & (valid_vec + 1'b1);
    assign cap_eff  = (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                          : CMP_W'(cap_reg);
    assign cap_zero = (cap_reg == '0);

    assign need_victim = (act_reg == lfu_pkg::ACT_PUT) && !present && !cap_zero &&
                         (CMP_W'(fill_reg) >= cap_eff);
    assign insert_free = (act_reg == lfu_pkg::ACT_PUT) && !present && !cap_zero &&
                         !need_victim;
    assign do_update   = (act_reg == lfu_pkg::ACT_GET) ? present : !cap_zero;

    assign sel_vec  = present ? match_vec : (need_victim ? victim_oh : free_oh);
    assign thr_rank = present ? found_rank : crank[ENTRIES];

    // sequencer
    assign out_free = !out_v_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                if (out_free && (!need_victim || cnt_reg == '0))
                begin
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready    = 1'b0;
        commit       = 1'b0;
        cnt_next     = cnt_reg;
        cmd.commit   = 1'b0;
        cmd.rank_all = !present && !need_victim;
        cmd.op       = lfu_pkg::OP_INSERT;
        if (present)
        begin
            cmd.op = (act_reg == lfu_pkg::ACT_GET) ? lfu_pkg::OP_BUMP_GET
                                                   : lfu_pkg::OP_BUMP_PUT;
        end
        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                cnt_next  = FILL_W'(ENTRIES);
            end
            lfu_pkg::ST_SCAN:
            begin
                commit = out_free && (!need_victim || cnt_reg == '0);
                cmd.commit = commit && do_update;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (commit && insert_free)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (commit)
            begin
                out_v_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // hold the request payload for the scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= req.action;
            key_reg <= KEY_BITS'({{KEY_BITS{1'b0}}, req.lookup_key});
            val_reg <= req.write_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_hit_reg   <= present;
            out_ev_reg    <= need_victim;
            out_evkey_reg <= need_victim
                           ? lfu_pkg::KEY_IN_W'({{lfu_pkg::KEY_IN_W{1'b0}}, ckey[ENTRIES]})
                           : '0;
            if (act_reg == lfu_pkg::ACT_GET)
            begin
                out_val_reg <= present ? found_val : lfu_pkg::MISS_VALUE;
            end
            else
            begin
                out_val_reg <= '0;
            end
        end
    end

    assign rsp.valid       = out_v_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.read_value  = out_val_reg;
    assign rsp.evicted     = out_ev_reg;
    assign rsp.evicted_key = out_evkey_reg;

    `LFU_ASSERT(a_fill_bound, (fill_reg <= FILL_W'(ENTRIES)))
    `LFU_ASSERT(a_sel_onehot, (cmd.commit |-> $onehot(sel_vec)))
    `LFU_ASSERT(a_rsp_from_commit, ($rose(out_v_reg) |-> $past(commit)))
    `LFU_ASSERT(a_accept_scan, (accept |=> state_reg == lfu_pkg::ST_SCAN))
    `LFU_ASSERT_RST(a_idle_in_reset, (!rst_n |=> state_reg == lfu_pkg::ST_IDLE))

endmodule

### rtl/lfu_cell.sv
// One table entry of the LFU cache with its stage of the victim-search chain.
// Depends on lfu_pkg.
module lfu_cell #(
    parameter int KEY_BITS = lfu_pkg::DEF_KEY_BITS,
    parameter int IDX_W    = 4,
    parameter int INDEX    = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfu_pkg::cell_cmd_t          cmd,
    input  logic                        sel,
    input  logic [IDX_W-1:0]            thr_rank,
    input  logic [KEY_BITS-1:0]         req_key,
    input  logic [lfu_pkg::DATA_W-1:0]  req_value,
    output logic                        match,
    output logic                        valid,
    output logic [lfu_pkg::DATA_W-1:0]  value,
    output logic [IDX_W-1:0]            rank,
    input  logic                        prev_v,
    input  logic [lfu_pkg::COUNT_W-1:0] prev_count,
    input  logic [IDX_W-1:0]            prev_rank,
    input  logic [IDX_W-1:0]            prev_idx,
    input  logic [KEY_BITS-1:0]         prev_key,
    output logic                        cand_v,
    output logic [lfu_pkg::COUNT_W-1:0] cand_count,
    output logic [IDX_W-1:0]            cand_rank,
    output logic [IDX_W-1:0]            cand_idx,
    output logic [KEY_BITS-1:0]         cand_key
);

    logic                        valid_reg;
    logic [KEY_BITS-1:0]         key_reg;
    logic [lfu_pkg::DATA_W-1:0]  value_reg;
    logic [lfu_pkg::COUNT_W-1:0] count_reg;
    logic [IDX_W-1:0]            rank_reg;
    logic [lfu_pkg::COUNT_W-1:0] count_inc;
    logic                        own_better;

    logic                        cand_v_reg;
    logic [lfu_pkg::COUNT_W-1:0] cand_count_reg;
    logic [IDX_W-1:0]            cand_rank_reg;
    logic [IDX_W-1:0]            cand_idx_reg;
    logic [KEY_BITS-1:0]         cand_key_reg;

    assign match = valid_reg && (key_reg == req_key);
    assign valid = valid_reg;
    assign value = value_reg;
    assign rank  = rank_reg;
    assign count_inc = (count_reg == lfu_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.commit && sel && cmd.op == lfu_pkg::OP_INSERT)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (sel)
            begin
                rank_reg <= '0;
                unique case (cmd.op)
                    lfu_pkg::OP_BUMP_GET:
                    begin
                        count_reg <= count_inc;
                    end
                    lfu_pkg::OP_BUMP_PUT:
                    begin
                        count_reg <= count_inc;
                        value_reg <= req_value;
                    end
                    lfu_pkg::OP_INSERT:
                    begin
                        count_reg <= lfu_pkg::COUNT_ONE;
                        value_reg <= req_value;
                        key_reg   <= req_key;
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
            end
            else if (valid_reg && (cmd.rank_all || rank_reg < thr_rank))
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    // lower count wins, older entry among equal counts
    assign own_better = valid_reg && (!prev_v || count_reg < prev_count ||
                        (count_reg == prev_count && rank_reg > prev_rank));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_v_reg <= 1'b0;
        end
        else
        begin
            cand_v_reg <= prev_v || valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (own_better)
        begin
            cand_count_reg <= count_reg;
            cand_rank_reg  <= rank_reg;
            cand_idx_reg   <= IDX_W'(INDEX);
            cand_key_reg   <= key_reg;
        end
        else
        begin
            cand_count_reg <= prev_count;
            cand_rank_reg  <= prev_rank;
            cand_idx_reg   <= prev_idx;
            cand_key_reg   <= prev_key;
        end
    end

    assign cand_v     = cand_v_reg;
    assign cand_count = cand_count_reg;
    assign cand_rank  = cand_rank_reg;
    assign cand_idx   = cand_idx_reg;
    assign cand_key   = cand_key_reg;

endmodule

### bench/tb_lfu_cache_table_unit.sv
// Testbench for lfu_cache_table_unit: directed table, capacity 1 and 0, then
// random get/put traffic checked against an in-bench LFU model with random idling
// on both channels. Depends on lfu_pkg and the interfaces in lfu_if.sv.
module tb_lfu_cache_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = lfu_pkg::DEF_ENTRIES;

    typedef struct {
        logic                         hit;
        logic [lfu_pkg::DATA_W-1:0]   read_value;
        logic                         evicted;
        logic [lfu_pkg::KEY_IN_W-1:0] evicted_key;
    } lookup_result_t;

    typedef struct {
        logic                         action;
        logic [lfu_pkg::KEY_IN_W-1:0] key;
        logic [lfu_pkg::DATA_W-1:0]   value;
        logic                         typed;
        logic                         hit;
        logic [lfu_pkg::DATA_W-1:0]   read_value;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lfu_req_if req ();
    lfu_rsp_if rsp ();
    lfu_cfg_if cfg ();

    lfu_cache_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #10 clk = ~clk;

    // cache model state
    logic [lfu_pkg::CAP_W-1:0]    model_cap;
    logic                         slot_used [SLOTS];
    logic [lfu_pkg::KEY_IN_W-1:0] slot_key_m [SLOTS];
    logic [lfu_pkg::DATA_W-1:0]   slot_val_m [SLOTS];
    logic [lfu_pkg::COUNT_W-1:0]  slot_cnt_m [SLOTS];
    int                           slot_rank_m [SLOTS];
    int                           fill_m;

    lookup_result_t expected_results[$];
    int             errors = 0;
    bit             burst_mode = 1'b0;
    logic [lfu_pkg::KEY_IN_W-1:0] key_pool[$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void touch(input int s);
        int r;
        r = slot_rank_m[s];
        if (slot_cnt_m[s] != lfu_pkg::COUNT_MAX)
            slot_cnt_m[s]++;
        for (int j = 0; j < SLOTS; j++)
            if (slot_used[j] && j != s && slot_rank_m[j] < r)
                slot_rank_m[j]++;
        slot_rank_m[s] = 0;
    endfunction

    function automatic void place(input int s, input logic [lfu_pkg::KEY_IN_W-1:0] k,
                                  input logic [lfu_pkg::DATA_W-1:0] v);
        for (int j = 0; j < SLOTS; j++)
            if (slot_used[j] && j != s)
                slot_rank_m[j]++;
        slot_used[s] = 1'b1;
        slot_key_m[s] = k;
        slot_val_m[s] = v;
        slot_cnt_m[s] = lfu_pkg::COUNT_ONE;
        slot_rank_m[s] = 0;
    endfunction

    function automatic lookup_result_t cache_access(input logic act,
                                                    input logic [lfu_pkg::KEY_IN_W-1:0] k,
                                                    input logic [lfu_pkg::DATA_W-1:0] v);
        lookup_result_t res;
        int found, cap, victim, r;
        found = -1;
        cap = (model_cap > SLOTS) ? SLOTS : int'(model_cap);
        for (int j = 0; j < SLOTS; j++)
            if (found < 0 && slot_used[j] && slot_key_m[j] == k)
                found = j;
        res.hit = (found >= 0);
        res.read_value = '0;
        res.evicted = 1'b0;
        res.evicted_key = '0;
        if (act == lfu_pkg::ACT_GET)
        begin
            if (found >= 0)
            begin
                res.read_value = slot_val_m[found];
                touch(found);
            end
            else
                res.read_value = lfu_pkg::MISS_VALUE;
            return res;
        end
        if (cap == 0)
            return res;
        if (found >= 0)
        begin
            slot_val_m[found] = v;
            touch(found);
        end
        else if (fill_m < cap)
        begin
            for (int j = 0; j < SLOTS; j++)
                if (!slot_used[j])
                begin
                    place(j, k, v);
                    fill_m++;
                    break;
                end
        end
        else
        begin
            victim = -1;
            for (int j = 0; j < SLOTS; j++)
            begin
                if (!slot_used[j])
                    continue;
                if (victim < 0 || slot_cnt_m[j] < slot_cnt_m[victim] ||
                    (slot_cnt_m[j] == slot_cnt_m[victim] &&
                     slot_rank_m[j] > slot_rank_m[victim]))
                    victim = j;
            end
            if (victim >= 0)
            begin
                r = slot_rank_m[victim];
                res.evicted = 1'b1;
                res.evicted_key = slot_key_m[victim];
                for (int j = 0; j < SLOTS; j++)
                    if (slot_used[j] && j != victim && slot_rank_m[j] > r)
                        slot_rank_m[j]--;
                slot_used[victim] = 1'b0;
                place(victim, k, v);
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        if (burst_mode)
            return 0;
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(0, 2);
    endfunction

    // one request transfer; the model advances at the accepting edge
    task automatic send_request(input logic act, input logic [lfu_pkg::KEY_IN_W-1:0] k,
                                input logic [lfu_pkg::DATA_W-1:0] v, input bit typed,
                                input lookup_result_t typed_res);
        int gap;
        lookup_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.lookup_key <= k;
        req.write_value <= v;
        do @(posedge clk); while (!req.ready);
        res = cache_access(act, k, v);
        expected_results.push_back(typed ? typed_res : res);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] c);
        cfg.valid <= 1'b1;
        cfg.cache_capacity <= c;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        model_cap = c;
    endtask

    // response side: random stalls, compare against the oldest expectation
    int stall_left = 0;
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report("unexpected transfer", 64'(1), 64'(0));
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.hit !== want.hit)
                    report("hit", 64'(rsp.hit), 64'(want.hit));
                if (rsp.read_value !== want.read_value)
                    report("read_value", 64'(rsp.read_value), 64'(want.read_value));
                if (rsp.evicted !== want.evicted)
                    report("evicted", 64'(rsp.evicted), 64'(want.evicted));
                if (rsp.evicted_key !== want.evicted_key)
                    report("evicted_key", 64'(rsp.evicted_key), 64'(want.evicted_key));
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready <= 1'b0;
        end
        else if (!burst_mode && $urandom_range(0, 5) == 0)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    stim_row_t dir_rows[$];
    int        caps[$];

    initial
    begin
        lookup_result_t tr;
        stim_row_t row;
        logic act;
        logic [lfu_pkg::KEY_IN_W-1:0] k;
        int n;

        req.valid = 1'b0;
        req.action = lfu_pkg::ACT_GET;
        req.lookup_key = '0;
        req.write_value = '0;
        cfg.valid = 1'b0;
        cfg.cache_capacity = '0;
        model_cap = lfu_pkg::CAP_RESET;
        fill_m = 0;
        for (int j = 0; j < SLOTS; j++)
        begin
            slot_used[j] = 1'b0;
            slot_key_m[j] = '0;
            slot_val_m[j] = '0;
            slot_cnt_m[j] = '0;
            slot_rank_m[j] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extreme keys and values, update, repeated get
        dir_rows = '{
            '{lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0,         1, 0, lfu_pkg::MISS_VALUE},
            '{lfu_pkg::ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 32'h0},
            '{lfu_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 32'h0},
            '{lfu_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 32'h0},
            '{lfu_pkg::ACT_PUT, 32'h0000_0000, 32'h0000_0000, 1, 0, 32'h0},
            '{lfu_pkg::ACT_GET, 32'h8000_0000, 32'h0,         1, 1, 32'h7FFF_FFFF},
            '{lfu_pkg::ACT_GET, 32'h7FFF_FFFF, 32'h0,         1, 1, 32'h8000_0000},
            '{lfu_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0,         1, 1, 32'hFFFF_FFFF},
            '{lfu_pkg::ACT_GET, 32'h0000_0001, 32'h0,         1, 0, lfu_pkg::MISS_VALUE},
            '{lfu_pkg::ACT_PUT, 32'h8000_0000, 32'h1234_5678, 1, 1, 32'h0},
            '{lfu_pkg::ACT_GET, 32'h8000_0000, 32'h0,         1, 1, 32'h1234_5678},
            '{lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0,         0, 0, 32'h0}
        };
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            tr.hit = row.hit;
            tr.read_value = row.read_value;
            tr.evicted = 1'b0;
            tr.evicted_key = '0;
            send_request(row.action, row.key, row.value, row.typed, tr);
        end
        drain();

        // capacity 1 with the table already over it: every new key evicts one entry
        write_capacity(5'd1);
        send_request(lfu_pkg::ACT_PUT, 32'h0000_00AA, 32'h1, 0, tr);
        send_request(lfu_pkg::ACT_PUT, 32'h0000_00BB, 32'h2, 0, tr);
        send_request(lfu_pkg::ACT_GET, 32'h0000_00AA, 32'h0, 0, tr);
        drain();
        // capacity 0: puts ignored, gets still report presence
        write_capacity(5'd0);
        send_request(lfu_pkg::ACT_PUT, 32'h0000_00CC, 32'h3, 0, tr);
        send_request(lfu_pkg::ACT_GET, 32'h0000_00CC, 32'h0, 0, tr);
        send_request(lfu_pkg::ACT_PUT, 32'h8000_0000, 32'h4, 0, tr);
        drain();

        // random phases; lowering 16 -> 3 leaves the table overfull
        caps = '{16, 3, 4, 0, 31, 9, 1, 16, 2};
        foreach (caps[p])
        begin
            write_capacity(caps[p][lfu_pkg::CAP_W-1:0]);
            burst_mode = ($urandom_range(0, 3) == 0);
            key_pool.delete();
            n = ((caps[p] > SLOTS) ? SLOTS : caps[p]) + $urandom_range(1, 6);
            repeat (n) key_pool.push_back($urandom());
            repeat (165)
            begin
                act = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0)
                    k = $urandom();
                else
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                send_request(act, k, $urandom(), 0, tr);
            end
            drain();
        end
        burst_mode = 1'b0;

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_if.sv
rtl/lfu_cell.sv
rtl/lfu_cache_table_unit.sv
bench/tb_lfu_cache_table_unit.sv
